// ----- hdl/spc_pkg.sv -----
`default_nettype none

package spc_pkg;

    // Item opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CMD    = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Commands carried with OP_CMD
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_HOME      = 3'd1;
    localparam logic [2:0] CMD_LONG_FWD  = 3'd2;
    localparam logic [2:0] CMD_SHORT_FWD = 3'd3;
    localparam logic [2:0] CMD_SWEEP_ON  = 3'd4;
    localparam logic [2:0] CMD_SWEEP_OFF = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOME_STEPS   = 2'd0;
    localparam logic [1:0] CFG_LONG_STEPS   = 2'd1;
    localparam logic [1:0] CFG_SHORT_STEPS  = 2'd2;
    localparam logic [1:0] CFG_SWEEP_PERIOD = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned STEP_W     = 16;

    // Configuration reset values
    localparam logic [STEP_W-1:0] HOME_STEPS_RST   = 16'd14000;
    localparam logic [STEP_W-1:0] LONG_STEPS_RST   = 16'd10500;
    localparam logic [STEP_W-1:0] SHORT_STEPS_RST  = 16'd7000;
    localparam logic [STEP_W-1:0] SWEEP_PERIOD_RST = 16'd21000;

    // Direction latch: 1 reverse, 0 forward
    localparam logic DIR_REVERSE = 1'b1;
    localparam logic DIR_FORWARD = 1'b0;

    typedef struct packed {
        logic [STEP_W-1:0] home_steps;
        logic [STEP_W-1:0] long_steps;
        logic [STEP_W-1:0] short_steps;
        logic [STEP_W-1:0] sweep_period;
    } t_cfg;

    typedef struct packed {
        logic [STEP_W-1:0] remaining_steps;
        logic              pulse_phase;
        logic              sweep_mode;
        logic [STEP_W-1:0] sweep_count;
        logic              sweep_dir;
        logic              homing_mark;
        logic              dir_latch;
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/spc_step.sv -----
`default_nettype none

module spc_step
    import spc_pkg::*;
(
    input  wire t_state     i_state,
    input  wire t_cfg       i_cfg,
    input  wire logic [1:0] i_opcode,
    input  wire logic [2:0] i_command,
    input  wire logic       i_sensor,
    output t_state          o_state,
    output logic            o_dir_write
);

    logic [STEP_W-1:0] w_rem;

    always_comb begin
        o_state     = i_state;
        o_dir_write = 1'b0;
        w_rem       = i_state.remaining_steps;

        case (i_opcode)
            OP_TICK: begin
                // End homing as soon as the sensor drops
                if (!i_sensor && i_state.homing_mark) begin
                    o_state.homing_mark = 1'b0;
                    w_rem               = '0;
                end
                o_state.remaining_steps = w_rem;
                if (!i_state.sweep_mode) begin
                    if (w_rem != '0) begin
                        o_state.pulse_phase = ~i_state.pulse_phase;
                        if (i_state.pulse_phase) begin
                            o_state.remaining_steps = w_rem - 1'b1;
                        end
                    end
                end else begin
                    if (i_state.sweep_count < i_cfg.sweep_period) begin
                        o_state.sweep_count = i_state.sweep_count + 1'b1;
                    end else begin
                        o_state.sweep_count = '0;
                        o_state.sweep_dir   = ~i_state.sweep_dir;
                        o_state.dir_latch   = i_state.sweep_dir ? DIR_FORWARD : DIR_REVERSE;
                        o_dir_write         = 1'b1;
                    end
                    o_state.pulse_phase = ~i_state.pulse_phase;
                end
            end
            OP_CMD: begin
                case (i_command)
                    CMD_HOME: begin
                        o_state.homing_mark     = 1'b1;
                        o_state.dir_latch       = DIR_REVERSE;
                        o_state.remaining_steps = i_cfg.home_steps;
                        o_dir_write             = 1'b1;
                    end
                    CMD_LONG_FWD: begin
                        o_state.homing_mark     = 1'b0;
                        o_state.dir_latch       = DIR_FORWARD;
                        o_state.remaining_steps = i_cfg.long_steps;
                        o_dir_write             = 1'b1;
                    end
                    CMD_SHORT_FWD: begin
                        o_state.homing_mark     = 1'b0;
                        o_state.dir_latch       = DIR_FORWARD;
                        o_state.remaining_steps = i_cfg.short_steps;
                        o_dir_write             = 1'b1;
                    end
                    CMD_SWEEP_ON: begin
                        o_state.sweep_mode = 1'b1;
                    end
                    CMD_SWEEP_OFF: begin
                        o_state.sweep_mode = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            OP_CHECK: begin
                // Homing check leaves the homing mark alone
                if (i_sensor) begin
                    o_state.dir_latch       = DIR_REVERSE;
                    o_state.remaining_steps = i_cfg.home_steps;
                    o_dir_write             = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/stepper_pulse_commander.sv -----
`default_nettype none

// Step pulse commander for a filter motor. Each request carries an opcode
// (tick, command or homing check), a command code and the position sensor
// level, and yields exactly one result: step pin level, a direction-write
// flag, the direction latch, the remaining step count and the sweep flag.
// The block takes one request per clock while the result side does not
// stall: the request lands in the input register, and its result loads into
// the result register when that register is free. The whole update of the
// motor state is one short pass of logic between those registers, so
// requests may follow back to back. A stall on the result side holds the
// result register and the input register; up to two requests sit in the
// block. Configuration registers (home_steps, long_steps, short_steps,
// sweep_period, indexes 0 to 3) are written through i_cfg_we and apply to
// every request processed after the write.

module stepper_pulse_commander
    import spc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [2:0]            i_command,
    input  wire logic                  i_sensor,

    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_step_pin,
    output logic                       o_dir_write,
    output logic                       o_dir_reverse,
    output logic [STEP_W-1:0]          o_steps_left,
    output logic                       o_sweeping,

    // Configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;

    // Input register
    logic       r_in_valid;
    logic [1:0] r_opcode;
    logic [2:0] r_command;
    logic       r_sensor;

    // Result register
    logic              r_out_valid;
    logic              r_step_pin;
    logic              r_dir_write;
    logic              r_dir_reverse;
    logic [STEP_W-1:0] r_steps_left;
    logic              r_sweeping;

    logic w_out_free;
    logic w_advance;
    logic w_accept;
    logic w_dir_write;

    // Result register can load when empty or when its content leaves now
    assign w_out_free = !r_out_valid || !i_out_stall;
    // The held request is processed and its result loaded
    assign w_advance  = r_in_valid && w_out_free;
    // Input register takes a new request when empty or draining
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.home_steps   <= HOME_STEPS_RST;
            r_cfg.long_steps   <= LONG_STEPS_RST;
            r_cfg.short_steps  <= SHORT_STEPS_RST;
            r_cfg.sweep_period <= SWEEP_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOME_STEPS:   r_cfg.home_steps   <= i_cfg_data;
                CFG_LONG_STEPS:   r_cfg.long_steps   <= i_cfg_data;
                CFG_SHORT_STEPS:  r_cfg.short_steps  <= i_cfg_data;
                CFG_SWEEP_PERIOD: r_cfg.sweep_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_opcode  <= i_opcode;
            r_command <= i_command;
            r_sensor  <= i_sensor;
        end
    end

    // Next motor state for the held request
    spc_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_opcode    (r_opcode),
        .i_command   (r_command),
        .i_sensor    (r_sensor),
        .o_state     (n_state),
        .o_dir_write (w_dir_write)
    );

    // Commit the state together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_step_pin    <= n_state.pulse_phase;
            r_dir_write   <= w_dir_write;
            r_dir_reverse <= n_state.dir_latch;
            r_steps_left  <= n_state.remaining_steps;
            r_sweeping    <= n_state.sweep_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_pin    = r_step_pin;
    assign o_dir_write   = r_dir_write;
    assign o_dir_reverse = r_dir_reverse;
    assign o_steps_left  = r_steps_left;
    assign o_sweeping    = r_sweeping;

    // A shown result always matches the committed state
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step_pin == r_state.pulse_phase
                      && o_steps_left == r_state.remaining_steps
                      && o_sweeping == r_state.sweep_mode
                      && o_dir_reverse == r_state.dir_latch))
        else $error("result register out of step with motor state");

    // An unused opcode leaves the state alone
    a_unused_opcode_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_opcode == OP_UNUSED) |=> (r_state == $past(r_state)))
        else $error("unused opcode changed motor state");

    // A processed request always produces a result
    a_advance_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("processed request produced no result");

    // An empty input register never stalls the request side
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall with empty input register");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import spc_pkg::*;

    // Spare command codes: decoded by nothing, so they must leave the motor alone
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int unsigned WATCHDOG_LIMIT  = 1000;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned PHASE_REQUESTS  = 160;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned MAX_WAIT        = 14;
    localparam logic [STEP_W-1:0] STEP_MAX  = '1;

    typedef struct packed {
        logic              step_pin;
        logic              dir_write;
        logic              dir_reverse;
        logic [STEP_W-1:0] steps_left;
        logic              sweeping;
    } pulse_report_t;

    // One row of the directed table; pinned rows carry a hand-written report
    typedef struct packed {
        logic [1:0]    opcode;
        logic [2:0]    command;
        logic          sensor;
        logic          pinned;
        pulse_report_t want;
    } motor_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic [1:0]            req_opcode = OP_TICK;
    logic [2:0]            req_command = CMD_NONE;
    logic                  req_sensor = 1'b0;

    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  rsp_step_pin;
    logic                  rsp_dir_write;
    logic                  rsp_dir_reverse;
    logic [STEP_W-1:0]     rsp_steps_left;
    logic                  rsp_sweeping;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_HOME_STEPS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the motor and its limits, advanced once per accepted request
    t_state                motor = '0;
    t_cfg                  limits = '{HOME_STEPS_RST, LONG_STEPS_RST,
                                      SHORT_STEPS_RST, SWEEP_PERIOD_RST};

    pulse_report_t         pending_reports[$];
    motor_row_t            directed_rows[$];
    int unsigned           error_count = 0;
    int unsigned           quiet_cycles = 0;
    logic                  send_burst = 1'b0;
    logic                  take_burst = 1'b0;

    stepper_pulse_commander dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .o_in_stall    (req_stall),
        .i_opcode      (req_opcode),
        .i_command     (req_command),
        .i_sensor      (req_sensor),
        .o_out_valid   (rsp_valid),
        .i_out_stall   (rsp_stall),
        .o_step_pin    (rsp_step_pin),
        .o_dir_write   (rsp_dir_write),
        .o_dir_reverse (rsp_dir_reverse),
        .o_steps_left  (rsp_steps_left),
        .o_sweeping    (rsp_sweeping),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the shadow motor by one request and report what the pins show after it.
    task automatic advance_motor(input logic [1:0] opcode, input logic [2:0] command,
                                 input logic sensor, output pulse_report_t report);
        logic wrote;
        wrote = 1'b0;
        case (opcode)
            OP_TICK: begin
                // The homing stop comes first: sensor low ends the homing move
                if (!sensor && motor.homing_mark) begin
                    motor.homing_mark     = 1'b0;
                    motor.remaining_steps = '0;
                end
                if (!motor.sweep_mode) begin
                    // Counted move: rise on one tick, fall and count on the next
                    if (motor.remaining_steps != '0) begin
                        if (!motor.pulse_phase) begin
                            motor.pulse_phase = 1'b1;
                        end else begin
                            motor.pulse_phase     = 1'b0;
                            motor.remaining_steps = motor.remaining_steps - 1'b1;
                        end
                    end
                end else begin
                    // Sweep: toggle forever, flip direction once per period+1 ticks.
                    // A count left above a lowered period also wraps and flips here.
                    if (motor.sweep_count < limits.sweep_period) begin
                        motor.sweep_count = motor.sweep_count + 1'b1;
                    end else begin
                        motor.sweep_count = '0;
                        motor.sweep_dir   = !motor.sweep_dir;
                        motor.dir_latch   = motor.sweep_dir ? DIR_REVERSE : DIR_FORWARD;
                        wrote             = 1'b1;
                    end
                    motor.pulse_phase = !motor.pulse_phase;
                end
            end
            OP_CMD: begin
                case (command)
                    CMD_HOME: begin
                        motor.homing_mark     = 1'b1;
                        motor.dir_latch       = DIR_REVERSE;
                        motor.remaining_steps = limits.home_steps;
                        wrote                 = 1'b1;
                    end
                    CMD_LONG_FWD: begin
                        motor.homing_mark     = 1'b0;
                        motor.dir_latch       = DIR_FORWARD;
                        motor.remaining_steps = limits.long_steps;
                        wrote                 = 1'b1;
                    end
                    CMD_SHORT_FWD: begin
                        motor.homing_mark     = 1'b0;
                        motor.dir_latch       = DIR_FORWARD;
                        motor.remaining_steps = limits.short_steps;
                        wrote                 = 1'b1;
                    end
                    CMD_SWEEP_ON:  motor.sweep_mode = 1'b1;
                    CMD_SWEEP_OFF: motor.sweep_mode = 1'b0;
                    default: ;
                endcase
            end
            OP_CHECK: begin
                // Homing check loads the homing move but leaves the homing mark alone
                if (sensor) begin
                    motor.dir_latch       = DIR_REVERSE;
                    motor.remaining_steps = limits.home_steps;
                    wrote                 = 1'b1;
                end
            end
            default: ;
        endcase
        report = '{motor.pulse_phase, wrote, motor.dir_latch,
                   motor.remaining_steps, motor.sweep_mode};
    endtask

    function automatic motor_row_t row(input logic [1:0] opcode, input logic [2:0] command,
                                       input logic sensor, input logic pinned,
                                       input logic pin, input logic dw, input logic rev,
                                       input logic [STEP_W-1:0] steps, input logic sw);
        row = '{opcode, command, sensor, pinned, '{pin, dw, rev, steps, sw}};
    endfunction

    function automatic logic [STEP_W-1:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            pick_limit = '0;
        end else if (r == 1) begin
            pick_limit = STEP_MAX;
        end else begin
            pick_limit = STEP_W'($urandom_range(1, 40));
        end
    endfunction

    // Present one request, hold it through any stall, and queue its report on acceptance.
    task automatic send_request(input logic [1:0] opcode, input logic [2:0] command,
                                input logic sensor, input logic pinned,
                                input pulse_report_t want);
        int unsigned   wait_cycles;
        pulse_report_t predicted;
        if ($urandom_range(0, 31) == 0) begin
            send_burst = !send_burst;
        end
        wait_cycles = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (wait_cycles != 0) begin
            req_valid <= 1'b0;
            repeat (wait_cycles) @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_opcode  <= opcode;
        req_command <= command;
        req_sensor  <= sensor;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        advance_motor(opcode, command, sensor, predicted);
        pending_reports.push_back(pinned ? want : predicted);
        @(negedge clk);
    endtask

    // Drop valid and hold until every queued report has come back.
    task automatic drain_reports();
        req_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_HOME_STEPS:   limits.home_steps   = value;
            CFG_LONG_STEPS:   limits.long_steps   = value;
            CFG_SHORT_STEPS:  limits.short_steps  = value;
            CFG_SWEEP_PERIOD: limits.sweep_period = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_limits(input logic [STEP_W-1:0] home, input logic [STEP_W-1:0] lng,
                               input logic [STEP_W-1:0] shrt, input logic [STEP_W-1:0] period);
        write_limit(CFG_HOME_STEPS, home);
        write_limit(CFG_LONG_STEPS, lng);
        write_limit(CFG_SHORT_STEPS, shrt);
        write_limit(CFG_SWEEP_PERIOD, period);
        cfg_we <= 1'b0;
    endtask

    // Random request: mostly ticks with the sensor high so moves run their course,
    // motion commands with random content, and some checks, spare codes and noise.
    task automatic send_random();
        int unsigned   r;
        logic [1:0]    opcode;
        logic [2:0]    command;
        logic          sensor;
        r       = $urandom_range(0, 99);
        command = 3'($urandom_range(0, 7));
        sensor  = 1'($urandom_range(0, 1));
        if (r < 62) begin
            opcode = OP_TICK;
            sensor = ($urandom_range(0, 9) != 0);
        end else if (r < 82) begin
            opcode = OP_CMD;
            if ($urandom_range(0, 4) != 0) begin
                command = 3'($urandom_range(CMD_HOME, CMD_SWEEP_OFF));
            end
        end else if (r < 94) begin
            opcode = OP_CHECK;
        end else begin
            opcode = OP_UNUSED;
        end
        send_request(opcode, command, sensor, 1'b0, '0);
    endtask

    // Result side: stall a random while per report, then take it and compare.
    initial begin : take_reports
        int unsigned   wait_cycles;
        pulse_report_t got;
        pulse_report_t want;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                take_burst = !take_burst;
            end
            wait_cycles = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (wait_cycles != 0) begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            got = '{rsp_step_pin, rsp_dir_write, rsp_dir_reverse, rsp_steps_left, rsp_sweeping};
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report %p", $time, got);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got.step_pin !== want.step_pin) begin
                    $display("%0t: step_pin expected %0b got %0b", $time,
                             want.step_pin, got.step_pin);
                    error_count++;
                end
                if (got.dir_write !== want.dir_write) begin
                    $display("%0t: dir_write expected %0b got %0b", $time,
                             want.dir_write, got.dir_write);
                    error_count++;
                end
                if (got.dir_reverse !== want.dir_reverse) begin
                    $display("%0t: dir_reverse expected %0b got %0b", $time,
                             want.dir_reverse, got.dir_reverse);
                    error_count++;
                end
                if (got.steps_left !== want.steps_left) begin
                    $display("%0t: steps_left expected %0d got %0d", $time,
                             want.steps_left, got.steps_left);
                    error_count++;
                end
                if (got.sweeping !== want.sweeping) begin
                    $display("%0t: sweeping expected %0b got %0b", $time,
                             want.sweeping, got.sweeping);
                    error_count++;
                end
            end
            @(negedge clk);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : drive_requests
        // Directed table, run on the reset limits. Pinned rows are read straight
        // off the reset values; the rest go through the shadow motor.
        directed_rows.push_back(row(OP_UNUSED, CMD_SPARE_HI, 1'b1, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b0, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CMD, CMD_NONE, 1'b1, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CMD, CMD_SPARE_LO, 1'b0, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CMD, CMD_SPARE_HI, 1'b1, 1, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CHECK, CMD_NONE, 1'b0, 1, 0, 0, 0, 0, 0));
        // Homing: reverse, full homing count, then stop on the sensor dropping
        directed_rows.push_back(row(OP_CMD, CMD_HOME, 1'b0, 1, 0, 1, DIR_REVERSE,
                                    HOME_STEPS_RST, 0));
        directed_rows.push_back(row(OP_TICK, CMD_SPARE_HI, 1'b1, 1, 1, 0, DIR_REVERSE,
                                    HOME_STEPS_RST, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b1, 1, 0, 0, DIR_REVERSE,
                                    HOME_STEPS_RST - 1'b1, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b0, 1, 0, 0, DIR_REVERSE, 0, 0));
        directed_rows.push_back(row(OP_CMD, CMD_LONG_FWD, 1'b1, 1, 0, 1, DIR_FORWARD,
                                    LONG_STEPS_RST, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CMD, CMD_SHORT_FWD, 1'b0, 0, 0, 0, 0, 0, 0));
        // Homing check leaves the mark clear, so a low sensor does not stop it
        directed_rows.push_back(row(OP_CHECK, CMD_NONE, 1'b1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b0, 0, 0, 0, 0, 0, 0));
        // Sweep over a pending count, then leave sweep with the pin high
        directed_rows.push_back(row(OP_CMD, CMD_SWEEP_ON, 1'b1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_TICK, CMD_SPARE_LO, 1'b0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CMD, CMD_SWEEP_OFF, 1'b0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_TICK, CMD_NONE, 1'b1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_UNUSED, CMD_HOME, 1'b0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(OP_CHECK, CMD_SPARE_HI, 1'b1, 0, 0, 0, 0, 0, 0));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].opcode, directed_rows[k].command,
                         directed_rows[k].sensor, directed_rows[k].pinned,
                         directed_rows[k].want);
        end

        // Random phases; limits change only with the block idle. The first two
        // phases pin the extremes, the rest mostly use short counts and periods
        // so that moves finish and sweeps reverse often. Motor state carries
        // over, so a period lowered under a running sweep count gets exercised.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_reports();
            if (phase == 0) begin
                load_limits('0, '0, '0, '0);
            end else if (phase == 1) begin
                load_limits(STEP_MAX, STEP_MAX, STEP_MAX, STEP_MAX);
            end else begin
                load_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
            end
            repeat (PHASE_REQUESTS) send_random();
        end

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
